@@ rtl/tapm_pkg.sv @@
// Shared types, constants and column handling functions of the position mapper.
package tapm_pkg;

   localparam int CHAR_W      = 8;
   localparam int POS_W       = 13;
   localparam int MAX_POS     = 4096;
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [POS_W-1:0]   POS_LIMIT   = POS_W'(MAX_POS);
   localparam logic [DEPTH_W-1:0] STACK_LIMIT = DEPTH_W'(STACK_DEPTH);

   localparam logic [CHAR_W-1:0] CH_OPEN     = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE    = 8'h29;
   localparam logic [CHAR_W-1:0] CH_LOWER    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_A        = 8'h61;
   localparam logic [CHAR_W-1:0] CH_C        = 8'h63;
   localparam logic [CHAR_W-1:0] CH_G        = 8'h67;
   localparam logic [CHAR_W-1:0] CH_T        = 8'h74;
   localparam logic [CHAR_W-1:0] CH_U        = 8'h75;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_UNDER    = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_TILDE    = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_NONE     = 8'h00;

   typedef enum logic {
      REC_MAP    = 1'b0,
      REC_LENGTH = 1'b1
   } record_kind_type;

   typedef struct packed {
      record_kind_type    record_kind;
      logic [POS_W-1:0]   top_index;
      logic [POS_W-1:0]   bottom_index;
      logic               error_flag;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] results;
      logic [CNT_W-1:0]             count;
   } bundle_type;

   typedef struct packed {
      logic               started;
      logic               pending_valid;
      logic [CHAR_W-1:0]  pending_top;
      logic [CHAR_W-1:0]  pending_bottom;
      logic [POS_W-1:0]   top_position;
      logic [POS_W-1:0]   bottom_position;
      logic               error_seen;
   } ctrl_state_type;

   localparam ctrl_state_type CTRL_RESET = '{
      started:         1'b0,
      pending_valid:   1'b0,
      pending_top:     '0,
      pending_bottom:  '0,
      top_position:    POS_W'(1),
      bottom_position: POS_W'(1),
      error_seen:      1'b0
   };

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               clear;
      logic [POS_W-1:0]   value;
   } stack_op_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [POS_W-1:0]   top;
      logic [POS_W-1:0]   below;
   } stack_view_type;

   typedef struct packed {
      logic [POS_W-1:0]             top_position;
      logic [POS_W-1:0]             bottom_position;
      logic [DEPTH_W-1:0]           top_depth;
      logic [DEPTH_W-1:0]           bottom_depth;
      logic [POS_W-1:0]             top_tos;
      logic [POS_W-1:0]             bottom_tos;
      logic [POS_W-1:0]             top_below;
      logic [POS_W-1:0]             bottom_below;
      logic                         error_seen;
      logic                         top_push;
      logic                         top_pop;
      logic                         bottom_push;
      logic                         bottom_pop;
      result_type [MAX_RESULTS-1:0] results;
      logic [CNT_W-1:0]             count;
   } column_ctx_type;

   function automatic logic is_base(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] l;
      l = c | CH_LOWER;
      return (l == CH_A) || (l == CH_C) || (l == CH_G) || (l == CH_T) || (l == CH_U);
   endfunction

   function automatic logic is_gap(logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_DOT) || (c == CH_UNDER) || (c == CH_DASH) ||
             (c == CH_TILDE);
   endfunction

   function automatic logic at_limit(logic [POS_W-1:0] p);
      return p >= POS_LIMIT;
   endfunction

   function automatic logic [POS_W-1:0] pos_step(logic [POS_W-1:0] p);
      return at_limit(p) ? p : p + POS_W'(1);
   endfunction

   function automatic column_ctx_type add_result(column_ctx_type c, record_kind_type kind,
                                                 logic [POS_W-1:0] ti, logic [POS_W-1:0] bi);
      column_ctx_type r;
      r = c;
      r.results[r.count[1:0]].record_kind  = kind;
      r.results[r.count[1:0]].top_index    = ti;
      r.results[r.count[1:0]].bottom_index = bi;
      r.results[r.count[1:0]].error_flag   = r.error_seen;
      r.count = r.count + CNT_W'(1);
      return r;
   endfunction

   function automatic logic is_pair(logic [CHAR_W-1:0] ct, logic [CHAR_W-1:0] cb,
                                    logic [CHAR_W-1:0] nt, logic [CHAR_W-1:0] nb);
      return (is_base(ct) && is_base(nt)) || (is_base(cb) && is_base(nb));
   endfunction

   function automatic column_ctx_type column_step(column_ctx_type c,
                                                  logic [CHAR_W-1:0] ct, logic [CHAR_W-1:0] cb,
                                                  logic [CHAR_W-1:0] nt, logic [CHAR_W-1:0] nb);
      column_ctx_type r;
      r = c;
      if (ct == CH_OPEN) begin
         if (r.top_depth >= STACK_LIMIT) begin
            r.error_seen = 1'b1;
         end else begin
            r.top_push  = 1'b1;
            r.top_depth = r.top_depth + DEPTH_W'(1);
            r.top_tos   = r.top_position;
         end
         if (!is_base(nt)) begin
            r.error_seen   = r.error_seen | at_limit(r.top_position);
            r.top_position = pos_step(r.top_position);
         end
      end
      if (cb == CH_OPEN) begin
         if (r.bottom_depth >= STACK_LIMIT) begin
            r.error_seen = 1'b1;
         end else begin
            r.bottom_push  = 1'b1;
            r.bottom_depth = r.bottom_depth + DEPTH_W'(1);
            r.bottom_tos   = r.bottom_position;
         end
         if (!is_base(nb)) begin
            r.error_seen      = r.error_seen | at_limit(r.bottom_position);
            r.bottom_position = pos_step(r.bottom_position);
         end
      end
      if (ct == CH_CLOSE) begin
         if (r.top_depth == '0) begin
            r.error_seen = 1'b1;
         end else begin
            r.top_pop   = 1'b1;
            r.top_depth = r.top_depth - DEPTH_W'(1);
            r.top_tos   = r.top_below;
         end
      end
      if (cb == CH_CLOSE) begin
         if (r.bottom_depth == '0) begin
            r.error_seen = 1'b1;
         end else begin
            r.bottom_pop   = 1'b1;
            r.bottom_depth = r.bottom_depth - DEPTH_W'(1);
            r.bottom_tos   = r.bottom_below;
         end
      end

      if (is_pair(ct, cb, nt, nb)) begin
         if (!is_gap(ct) && !is_gap(cb)) begin
            if ((r.top_depth == '0) || (r.bottom_depth == '0)) begin
               r.error_seen = 1'b1;
            end else begin
               r = add_result(r, REC_MAP, r.top_tos, r.bottom_tos);
            end
         end
         if (!is_gap(nt) && !is_gap(nb)) begin
            r = add_result(r, REC_MAP, r.top_position, r.bottom_position);
         end
         if (!is_gap(nt)) begin
            r.error_seen   = r.error_seen | at_limit(r.top_position);
            r.top_position = pos_step(r.top_position);
         end
         if (!is_gap(nb)) begin
            r.error_seen      = r.error_seen | at_limit(r.bottom_position);
            r.bottom_position = pos_step(r.bottom_position);
         end
      end else if (is_base(ct) || is_base(cb)) begin
         if (!is_gap(ct) && !is_gap(cb)) begin
            r = add_result(r, REC_MAP, r.top_position, r.bottom_position);
         end
         if (!is_gap(cb)) begin
            r.error_seen      = r.error_seen | at_limit(r.bottom_position);
            r.bottom_position = pos_step(r.bottom_position);
         end
         if (!is_gap(ct)) begin
            r.error_seen   = r.error_seen | at_limit(r.top_position);
            r.top_position = pos_step(r.top_position);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/tree_alignment_position_mapper.sv @@
// Top level of the tree alignment position mapper: input register, column logic, stacks, results.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_top_char, req_bottom_char, req_final_column
//   rsp      out        rsp_valid/rsp_ready    rsp_record_kind, rsp_top_index,
//                                              rsp_bottom_index, rsp_error_flag, rsp_run_end
//
// A column enters the input register, is handled from there once the result register can take
// its results, and its results land in the result register.
// One column per cycle while each column causes at most one result and rsp_ready stays high; a
// column with two or three results holds the input side until only its last result is left there.
// Synchronous reset clears control state and both stack depths; no clearing pass.
// A stalled result side fills the input register, then drops req_ready.
module tree_alignment_position_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_top_char,
   input  logic [7:0]  req_bottom_char,
   input  logic        req_final_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [12:0] rsp_top_index,
   output logic [12:0] rsp_bottom_index,
   output logic        rsp_error_flag,
   output logic        rsp_run_end
);
   import tapm_pkg::*;

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_top_ff;
   logic [CHAR_W-1:0] in_bottom_ff;
   logic              in_final_ff;
   ctrl_state_type    ctrl_ff;
   ctrl_state_type    ctrl_in;
   stack_view_type    top_view;
   stack_view_type    bottom_view;
   stack_op_type      top_op;
   stack_op_type      bottom_op;
   stack_op_type      top_op_gated;
   stack_op_type      bottom_op_gated;
   bundle_type        bundle;
   result_type        head;
   logic              head_last;
   logic              load_ready;
   logic              process;

   assign process   = in_valid_ff && load_ready;
   assign req_ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_top_ff    <= req_top_char;
         in_bottom_ff <= req_bottom_char;
         in_final_ff  <= req_final_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CTRL_RESET;
      end else if (process) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_comb begin
      top_op_gated    = process ? top_op : '0;
      bottom_op_gated = process ? bottom_op : '0;
   end

   tapm_step u_step (
      .state        (ctrl_ff),
      .top_char     (in_top_ff),
      .bottom_char  (in_bottom_ff),
      .final_column (in_final_ff),
      .top_view     (top_view),
      .bottom_view  (bottom_view),
      .next_state   (ctrl_in),
      .top_op       (top_op),
      .bottom_op    (bottom_op),
      .bundle       (bundle)
   );

   tapm_stack u_top_stack (
      .clock (clock),
      .reset (reset),
      .op    (top_op_gated),
      .view  (top_view)
   );

   tapm_stack u_bottom_stack (
      .clock (clock),
      .reset (reset),
      .op    (bottom_op_gated),
      .view  (bottom_view)
   );

   tapm_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (process),
      .bundle     (bundle),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .head       (head),
      .head_last  (head_last)
   );

   assign rsp_record_kind  = head.record_kind;
   assign rsp_top_index    = head.top_index;
   assign rsp_bottom_index = head.bottom_index;
   assign rsp_error_flag   = head.error_flag;
   assign rsp_run_end      = head_last;

endmodule

@@ rtl/tapm_stack.sv @@
// Position stack of one row: top and next-below held in registers, the rest in a memory.
module tapm_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  tapm_pkg::stack_op_type   op,
   output tapm_pkg::stack_view_type view
);
   import tapm_pkg::*;

   logic [POS_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [POS_W-1:0]   tos_ff;
   logic [POS_W-1:0]   tos_in;
   logic [POS_W-1:0]   below_ff;
   logic [DEPTH_W-1:0] wr_pos;
   logic [DEPTH_W-1:0] rd_pos;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;

   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      if (op.clear) begin
         depth_in = '0;
      end else if (op.push) begin
         depth_in = depth_ff + DEPTH_W'(1);
         tos_in   = op.value;
      end else if (op.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
         tos_in   = below_ff;
      end
      wr_en   = op.push && !op.clear && (depth_ff != '0);
      wr_pos  = depth_ff - DEPTH_W'(1);
      rd_pos  = depth_in - DEPTH_W'(2);
      wr_addr = wr_pos[ADDR_W-1:0];
      rd_addr = rd_pos[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      if (wr_en) begin
         stack_mem[wr_addr] <= tos_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= tos_ff;
      end else begin
         below_ff <= stack_mem[rd_addr];
      end
   end

   assign view.depth = depth_ff;
   assign view.top   = tos_ff;
   assign view.below = below_ff;

endmodule

@@ rtl/tapm_step.sv @@
// Column handling for one transaction: next control state, stack operations and results.
module tapm_step (
   input  tapm_pkg::ctrl_state_type state,
   input  logic [7:0]               top_char,
   input  logic [7:0]               bottom_char,
   input  logic                     final_column,
   input  tapm_pkg::stack_view_type top_view,
   input  tapm_pkg::stack_view_type bottom_view,
   output tapm_pkg::ctrl_state_type next_state,
   output tapm_pkg::stack_op_type   top_op,
   output tapm_pkg::stack_op_type   bottom_op,
   output tapm_pkg::bundle_type     bundle
);
   import tapm_pkg::*;

   column_ctx_type ctx;
   ctrl_state_type nxt;
   logic           consumed;

   always_comb begin
      ctx.top_position    = state.top_position;
      ctx.bottom_position = state.bottom_position;
      ctx.top_depth       = top_view.depth;
      ctx.bottom_depth    = bottom_view.depth;
      ctx.top_tos         = top_view.top;
      ctx.bottom_tos      = bottom_view.top;
      ctx.top_below       = top_view.below;
      ctx.bottom_below    = bottom_view.below;
      ctx.error_seen      = state.error_seen;
      ctx.top_push        = 1'b0;
      ctx.top_pop         = 1'b0;
      ctx.bottom_push     = 1'b0;
      ctx.bottom_pop      = 1'b0;
      ctx.results         = '0;
      ctx.count           = '0;
      nxt                 = state;
      consumed            = 1'b0;

      if (!state.started) begin
         nxt.started = 1'b1;
         ctx = add_result(ctx, REC_MAP, '0, '0);
      end else begin
         if (state.pending_valid) begin
            ctx = column_step(ctx, state.pending_top, state.pending_bottom,
                              top_char, bottom_char);
            consumed = is_pair(state.pending_top, state.pending_bottom,
                               top_char, bottom_char);
            nxt.pending_valid = 1'b0;
         end
         if (!consumed) begin
            if (final_column) begin
               ctx = column_step(ctx, top_char, bottom_char, CH_NONE, CH_NONE);
            end else begin
               nxt.pending_top    = top_char;
               nxt.pending_bottom = bottom_char;
               nxt.pending_valid  = 1'b1;
            end
         end
      end
      nxt.top_position    = ctx.top_position;
      nxt.bottom_position = ctx.bottom_position;
      nxt.error_seen      = ctx.error_seen;

      if (final_column) begin
         ctx = add_result(ctx, REC_LENGTH, ctx.top_position - POS_W'(1), '0);
         nxt = CTRL_RESET;
      end
   end

   assign next_state      = nxt;
   assign bundle.results  = ctx.results;
   assign bundle.count    = ctx.count;
   assign top_op.push     = ctx.top_push;
   assign top_op.pop      = ctx.top_pop;
   assign top_op.clear    = final_column;
   assign top_op.value    = ctx.top_tos;
   assign bottom_op.push  = ctx.bottom_push;
   assign bottom_op.pop   = ctx.bottom_pop;
   assign bottom_op.clear = final_column;
   assign bottom_op.value = ctx.bottom_tos;

endmodule

@@ rtl/tapm_out_buffer.sv @@
// Result register holding up to three results of one transaction, drained in order.
module tapm_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tapm_pkg::bundle_type bundle,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tapm_pkg::result_type head,
   output logic                 head_last
);
   import tapm_pkg::*;

   result_type       res_ff  [MAX_RESULTS];
   logic             last_ff [MAX_RESULTS];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] last_idx;

   assign rsp_valid  = (cnt_ff != '0);
   assign load_ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);
   assign last_idx   = bundle.count - CNT_W'(1);
   assign head       = res_ff[0];
   assign head_last  = last_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.count;
      end else if (rsp_valid && rsp_ready) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_ff[i]  <= bundle.results[i];
            last_ff[i] <= (last_idx == CNT_W'(i));
         end
      end else if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_ff[i]  <= res_ff[i+1];
            last_ff[i] <= last_ff[i+1];
         end
      end
   end

endmodule

@@ dv/tb_tree_alignment_position_mapper.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the tree alignment position mapper, with its own column predictor.
module tb_tree_alignment_position_mapper;
   import tapm_pkg::*;

   typedef struct {
      record_kind_type kind;
      logic [12:0]     top_index;
      logic [12:0]     bottom_index;
      logic            error_flag;
      logic            run_end;
   } map_write_t;

   localparam logic [7:0] BASE_SET [10] = '{"A", "a", "C", "c", "G", "g", "T", "t", "U", "u"};
   localparam logic [7:0] GAP_SET  [5]  = '{" ", ".", "_", "-", "~"};
   localparam logic [7:0] FILLER_CHAR  = "N";

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_top_char;
   logic [7:0]  req_bottom_char;
   logic        req_final_column;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_record_kind;
   logic [12:0] rsp_top_index;
   logic [12:0] rsp_bottom_index;
   logic        rsp_error_flag;
   logic        rsp_run_end;

   logic        col_started;
   logic        col_pending;
   logic [7:0]  pending_top_ch;
   logic [7:0]  pending_bottom_ch;
   logic [12:0] row_pos   [2];
   logic [8:0]  row_depth [2];
   logic [12:0] row_stack [2][STACK_DEPTH];
   logic        sticky_error;

   map_write_t  expected_writes [$];
   map_write_t  step_writes [$];
   int          mismatch_count = 0;
   bit          quiet = 1'b0;

   tree_alignment_position_mapper u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_top_char     (req_top_char),
      .req_bottom_char  (req_bottom_char),
      .req_final_column (req_final_column),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_top_index    (rsp_top_index),
      .rsp_bottom_index (rsp_bottom_index),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_run_end      (rsp_run_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit is_base_char(logic [7:0] c);
      foreach (BASE_SET[i]) begin
         if (c == BASE_SET[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit is_gap_char(logic [7:0] c);
      foreach (GAP_SET[i]) begin
         if (c == GAP_SET[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void restart_alignment();
      col_started       = 1'b0;
      col_pending       = 1'b0;
      pending_top_ch    = '0;
      pending_bottom_ch = '0;
      sticky_error      = 1'b0;
      for (int r = 0; r < 2; r++) begin
         row_pos[r]   = 13'd1;
         row_depth[r] = '0;
      end
   endfunction

   function automatic void advance_row(int r);
      if (row_pos[r] >= MAX_POS) sticky_error = 1'b1;
      else row_pos[r] = row_pos[r] + 13'd1;
   endfunction

   function automatic void push_row(int r);
      if (row_depth[r] >= STACK_DEPTH) begin
         sticky_error = 1'b1;
      end else begin
         row_stack[r][row_depth[r]] = row_pos[r];
         row_depth[r] = row_depth[r] + 9'd1;
      end
   endfunction

   function automatic void pop_row(int r);
      if (row_depth[r] == 0) sticky_error = 1'b1;
      else row_depth[r] = row_depth[r] - 9'd1;
   endfunction

   function automatic void add_write(record_kind_type kind, logic [12:0] t, logic [12:0] b);
      map_write_t w;
      w = '{kind, t, b, sticky_error, 1'b0};
      step_writes.push_back(w);
   endfunction

   // Handle one column against its lookahead; returns 1 when the lookahead is consumed.
   function automatic bit handle_column(logic [7:0] ct, logic [7:0] cb,
                                        logic [7:0] nt, logic [7:0] nb);
      logic [7:0] cur [2];
      logic [7:0] nxt [2];
      cur[0] = ct;
      cur[1] = cb;
      nxt[0] = nt;
      nxt[1] = nb;
      for (int r = 0; r < 2; r++) begin
         if (cur[r] == CH_OPEN) begin
            push_row(r);
            if (!is_base_char(nxt[r])) advance_row(r);
         end
      end
      for (int r = 0; r < 2; r++) begin
         if (cur[r] == CH_CLOSE) pop_row(r);
      end
      if ((is_base_char(ct) && is_base_char(nt)) || (is_base_char(cb) && is_base_char(nb))) begin
         if (!is_gap_char(ct) && !is_gap_char(cb)) begin
            if (row_depth[0] == 0 || row_depth[1] == 0) begin
               sticky_error = 1'b1;
            end else begin
               add_write(REC_MAP, row_stack[0][row_depth[0] - 9'd1],
                         row_stack[1][row_depth[1] - 9'd1]);
            end
         end
         if (!is_gap_char(nt) && !is_gap_char(nb)) add_write(REC_MAP, row_pos[0], row_pos[1]);
         for (int r = 0; r < 2; r++) begin
            if (!is_gap_char(nxt[r])) advance_row(r);
         end
         return 1'b1;
      end
      if (is_base_char(ct) || is_base_char(cb)) begin
         if (!is_gap_char(ct) && !is_gap_char(cb)) add_write(REC_MAP, row_pos[0], row_pos[1]);
         for (int r = 0; r < 2; r++) begin
            if (!is_gap_char(cur[r])) advance_row(r);
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_column(logic [7:0] t, logic [7:0] b, logic fin);
      bit used;
      used = 1'b0;
      step_writes.delete();
      if (!col_started) begin
         col_started = 1'b1;
         add_write(REC_MAP, '0, '0);
      end else begin
         if (col_pending) begin
            used = handle_column(pending_top_ch, pending_bottom_ch, t, b);
            col_pending = 1'b0;
         end
         if (!used) begin
            if (fin) begin
               void'(handle_column(t, b, CH_NONE, CH_NONE));
            end else begin
               pending_top_ch    = t;
               pending_bottom_ch = b;
               col_pending       = 1'b1;
            end
         end
      end
      if (fin) begin
         add_write(REC_LENGTH, row_pos[0] - 13'd1, '0);
         restart_alignment();
      end
      if (step_writes.size() > 0) step_writes[step_writes.size() - 1].run_end = 1'b1;
      foreach (step_writes[i]) expected_writes.push_back(step_writes[i]);
   endfunction

   task automatic send_column(logic [7:0] t, logic [7:0] b, logic fin);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_top_char     <= t;
      req_bottom_char  <= b;
      req_final_column <= fin;
      do @(posedge clock); while (!req_ready);
      predict_column(t, b, fin);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_directed();
      send_column("A", "U", 1'b1);

      send_column(FILLER_CHAR, FILLER_CHAR, 1'b0);
      send_column(CH_OPEN, CH_OPEN, 1'b0);
      send_column("A", "G", 1'b0);
      send_column("C", "U", 1'b0);
      send_column(CH_CLOSE, CH_CLOSE, 1'b0);
      send_column("a", "-", 1'b0);
      send_column("-", "t", 1'b0);
      send_column("~", "_", 1'b0);
      send_column(".", " ", 1'b0);
      send_column(8'hFF, 8'h00, 1'b0);
      send_column("g", "c", 1'b1);

      send_column("A", "A", 1'b0);
      send_column(CH_CLOSE, "C", 1'b0);
      send_column("G", CH_CLOSE, 1'b1);

      send_column("A", "A", 1'b0);
      send_column("A", "A", 1'b0);
      send_column("C", "-", 1'b0);
      send_column("g", "U", 1'b1);

      send_column(8'h00, 8'hFF, 1'b0);
      send_column(8'hFF, 8'h00, 1'b0);
      send_column(8'hFF, 8'hFF, 1'b1);
   endtask

   task automatic test_random_alignments(int item_goal);
      int         sent;
      int         span;
      int         pick;
      bit         noise;
      int         depth [2];
      logic [7:0] ch [2];
      sent = 0;
      while (sent < item_goal) begin
         span  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
         noise = ($urandom_range(0, 7) == 0);
         depth[0] = 0;
         depth[1] = 0;
         for (int c = 0; c < span; c++) begin
            for (int r = 0; r < 2; r++) begin
               pick = $urandom_range(0, 9);
               if (noise || pick == 9) begin
                  ch[r] = 8'($urandom_range(0, 255));
               end else if (pick <= 1) begin
                  ch[r] = CH_OPEN;
                  depth[r]++;
               end else if (pick <= 3 && depth[r] > 0) begin
                  ch[r] = CH_CLOSE;
                  depth[r]--;
               end else if (pick == 8) begin
                  ch[r] = GAP_SET[$urandom_range(0, 4)];
               end else begin
                  ch[r] = BASE_SET[$urandom_range(0, 9)];
               end
            end
            send_column(ch[0], ch[1], c == span - 1);
         end
         sent += span;
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      map_write_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected transaction: kind %0d top %0d bottom %0d",
                   rsp_record_kind, rsp_top_index, rsp_bottom_index);
            mismatch_count++;
         end else begin
            want = expected_writes.pop_front();
            if (rsp_record_kind !== want.kind) begin
               $error("record_kind: expected %0d, actual %0d", want.kind, rsp_record_kind);
               mismatch_count++;
            end
            if (rsp_top_index !== want.top_index) begin
               $error("top_index: expected %0d, actual %0d", want.top_index, rsp_top_index);
               mismatch_count++;
            end
            if (rsp_bottom_index !== want.bottom_index) begin
               $error("bottom_index: expected %0d, actual %0d", want.bottom_index,
                      rsp_bottom_index);
               mismatch_count++;
            end
            if (rsp_error_flag !== want.error_flag) begin
               $error("error_flag: expected %0d, actual %0d", want.error_flag, rsp_error_flag);
               mismatch_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, actual %0d", want.run_end, rsp_run_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_top_char     = '0;
      req_bottom_char  = '0;
      req_final_column = 1'b0;
      restart_alignment();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_results();
      test_random_alignments(120);
      wait_for_results();
      quiet = 1'b1;
      test_random_alignments(110);
      wait_for_results();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_writes.size() == 0) begin
         $display("tree_alignment_position_mapper regression: pass");
      end else begin
         $display("tree_alignment_position_mapper regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tree_alignment_position_mapper regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tapm_pkg.sv
rtl/tapm_stack.sv
rtl/tapm_step.sv
rtl/tapm_out_buffer.sv
rtl/tree_alignment_position_mapper.sv
dv/tb_tree_alignment_position_mapper.sv
